[sv/key_to_integer_normalizer_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the key to integer normalizer.
// Each macro expands to one labeled concurrent assertion on i_clk, disabled
// while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEY_TO_INTEGER_NORMALIZER_UNIT_MACROS_SVH
`define KEY_TO_INTEGER_NORMALIZER_UNIT_MACROS_SVH

// The condition must hold in the same cycle.
`define K2I_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define K2I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/k2i_pkg.sv]
// ---------------------------------------------------------------------------
// k2i_pkg
// Types and constants shared by the key to integer normalizer modules.
// ---------------------------------------------------------------------------
package k2i_pkg;

    localparam int unsigned KEY_VALUE_W = 64;
    localparam int unsigned COUNT_W     = 5;

    // Length of the hex prefix and the number of decimal digits kept.
    localparam logic [COUNT_W-1:0] HEX_PREFIX_LEN = 5'd16;
    localparam logic [COUNT_W-1:0] MAX_DEC_DIGITS = 5'd19;

    typedef enum logic [1:0] {
        RULE_HEX  = 2'd0,
        RULE_DEC  = 2'd1,
        RULE_TAIL = 2'd2
    } t_rule;

    typedef struct packed {
        logic [KEY_VALUE_W-1:0] key_value;
        t_rule                  rule_used;
    } t_result;

    // Bit 4 set means the byte is not a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] nib;
        begin
            if (b >= 8'h30 && b <= 8'h39) begin
                nib = {1'b0, b[3:0]};
            end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
                nib = {1'b0, b[3:0] + 4'd9};
            end else begin
                nib = 5'h10;
            end
            return nib;
        end
    endfunction

endpackage

[sv/key_to_integer_normalizer_unit.sv]
// A key's result, at its final byte or empty-key mark, is registered in the
// output register, or in the skid slot on a stall. Throughput: one key byte
// per cycle while the skid slot is empty; the per-byte accumulator update is
// the single combinational step between input beat and result register.
// Reset: synchronous, active low; clears all key state and both output slots.
// ---------------------------------------------------------------------------
// key_to_integer_normalizer_unit
// Converts a byte-serial key into a 64-bit number by hex prefix, decimal
// digits or trailing bytes, with an output register and a skid slot.
// ---------------------------------------------------------------------------
`include "key_to_integer_normalizer_unit_macros.svh"

module key_to_integer_normalizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic        s_axis_tuser,   // [0] empty_key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] key_value
    output logic [1:0]  m_axis_tuser    // [1:0] rule_used
);

    k2i_pkg::t_result result;
    k2i_pkg::t_result r_out,   n_out;
    k2i_pkg::t_result r_skid,  n_skid;
    logic             r_out_valid,  n_out_valid;
    logic             r_skid_valid, n_skid_valid;

    logic beat_en;
    logic produce;
    logic out_free;

    assign s_axis_tready = !r_skid_valid;
    assign beat_en       = s_axis_tvalid && s_axis_tready;
    assign produce       = beat_en && (s_axis_tlast || s_axis_tuser);
    assign out_free      = !r_out_valid || m_axis_tready;

    k2i_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat_en   (beat_en),
        .i_key_byte  (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_empty_key (s_axis_tuser),
        .o_result    (result)
    );

    // A result that finds the output register stalled waits in the skid slot;
    // the input stops only while that slot is full.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = result;
                n_out_valid = produce;
            end
        end else if (produce) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.key_value;
    assign m_axis_tuser  = r_out.rule_used;

    `K2I_ASSERT_NOW(a_skid_implies_out, !r_skid_valid || r_out_valid, "skid slot full while output register empty")
    `K2I_ASSERT_NEXT(a_skid_fill_only_on_stall, !r_skid_valid && !(r_out_valid && !m_axis_tready), !r_skid_valid, "skid slot filled without an output stall")

endmodule

[sv/k2i_accum.sv]
// ---------------------------------------------------------------------------
// k2i_accum
// Per-key accumulators: hex prefix, decimal digits and the trailing byte
// window. Updated on every accepted beat; the result for a finished key is
// formed combinationally from the updated values.
// ---------------------------------------------------------------------------
`include "key_to_integer_normalizer_unit_macros.svh"

module k2i_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat_en,
    input  logic [7:0]       i_key_byte,
    input  logic             i_last_byte,
    input  logic             i_empty_key,
    output k2i_pkg::t_result o_result
);

    logic [k2i_pkg::COUNT_W-1:0]     r_bytes_seen,  n_bytes_seen;
    logic                            r_prefix_hex,  n_prefix_hex;
    logic [k2i_pkg::KEY_VALUE_W-1:0] r_hex_acc,     n_hex_acc;
    logic [k2i_pkg::KEY_VALUE_W-1:0] r_dec_acc,     n_dec_acc;
    logic [k2i_pkg::COUNT_W-1:0]     r_digits,      n_digits;
    logic [k2i_pkg::KEY_VALUE_W-1:0] r_tail,        n_tail;

    logic [4:0] nib;
    logic       is_digit;

    always_comb begin
        nib      = k2i_pkg::hex_nibble(i_key_byte);
        is_digit = (i_key_byte >= 8'h30) && (i_key_byte <= 8'h39);

        n_bytes_seen = r_bytes_seen;
        n_prefix_hex = r_prefix_hex;
        n_hex_acc    = r_hex_acc;
        n_dec_acc    = r_dec_acc;
        n_digits     = r_digits;

        if (r_bytes_seen < k2i_pkg::HEX_PREFIX_LEN) begin
            if (nib[4]) begin
                n_prefix_hex = 1'b0;
            end else begin
                n_hex_acc = {r_hex_acc[k2i_pkg::KEY_VALUE_W-5:0], nib[3:0]};
            end
            n_bytes_seen = r_bytes_seen + 5'd1;
        end

        // Nineteen digits always fit, so times ten plus digit never wraps.
        if (is_digit && (r_digits < k2i_pkg::MAX_DEC_DIGITS)) begin
            n_dec_acc = (r_dec_acc << 3) + (r_dec_acc << 1)
                      + {{(k2i_pkg::KEY_VALUE_W-4){1'b0}}, i_key_byte[3:0]};
            n_digits  = r_digits + 5'd1;
        end

        n_tail = {r_tail[k2i_pkg::KEY_VALUE_W-9:0], i_key_byte};

        if (i_empty_key) begin
            o_result.key_value = '0;
            o_result.rule_used = k2i_pkg::RULE_TAIL;
        end else if ((n_bytes_seen == k2i_pkg::HEX_PREFIX_LEN) && n_prefix_hex) begin
            o_result.key_value = n_hex_acc;
            o_result.rule_used = k2i_pkg::RULE_HEX;
        end else if (n_digits != '0) begin
            o_result.key_value = n_dec_acc;
            o_result.rule_used = k2i_pkg::RULE_DEC;
        end else begin
            o_result.key_value = n_tail;
            o_result.rule_used = k2i_pkg::RULE_TAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_prefix_hex <= 1'b1;
            r_hex_acc    <= '0;
            r_dec_acc    <= '0;
            r_digits     <= '0;
            r_tail       <= '0;
        end else if (i_beat_en) begin
            if (i_empty_key || i_last_byte) begin
                r_bytes_seen <= '0;
                r_prefix_hex <= 1'b1;
                r_hex_acc    <= '0;
                r_dec_acc    <= '0;
                r_digits     <= '0;
                r_tail       <= '0;
            end else begin
                r_bytes_seen <= n_bytes_seen;
                r_prefix_hex <= n_prefix_hex;
                r_hex_acc    <= n_hex_acc;
                r_dec_acc    <= n_dec_acc;
                r_digits     <= n_digits;
                r_tail       <= n_tail;
            end
        end
    end

    `K2I_ASSERT_NOW(a_counts_bounded, (r_bytes_seen <= k2i_pkg::HEX_PREFIX_LEN) && (r_digits <= k2i_pkg::MAX_DEC_DIGITS), "key counters out of range")
    `K2I_ASSERT_NEXT(a_state_clear_after_key, i_beat_en && (i_last_byte || i_empty_key), (r_bytes_seen == '0) && (r_digits == '0) && r_prefix_hex, "key state not cleared after a finished key")

endmodule
